>>> rtl/swrm_pkg.sv
// Shared types and constants of the sliding window rate meter.
`default_nettype none

package swrm_pkg;

    localparam int WINDOW_DEPTH = 512;
    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 32 + PTR_W;
    localparam int NUM_W = SUM_W + 10;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [31:0] WINDOW_MS_RESET = 32'd40000;
    localparam logic [8:0] MIN_COUNT_RESET = 9'd10;

    localparam logic [0:0] REG_WINDOW_MS = 1'b0;
    localparam logic [0:0] REG_MIN_COUNT = 1'b1;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] bytes;
    } entry_t;

    typedef struct packed {
        logic done;
        logic saturated;
    } div_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FULL_RD,
        S_FULL_DROP,
        S_APPEND,
        S_EV_RD,
        S_EV_CHK,
        S_MUL1,
        S_MUL2,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> rtl/swrm_if.sv
// Valid/ready channel interfaces for sample transactions and rate transactions.
`default_nettype none

interface swrm_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] sample_bytes;
    logic [31:0] timestamp_ms;

    modport source (output valid, output mode, output sample_bytes, output timestamp_ms,
                    input ready);
    modport sink (input valid, input mode, input sample_bytes, input timestamp_ms,
                  output ready);
endinterface

interface swrm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rate_bytes_per_s;
    logic        rate_saturated;
    logic        capacity_drop;

    modport source (output valid, output rate_bytes_per_s, output rate_saturated,
                    output capacity_drop, input ready);
    modport sink (input valid, input rate_bytes_per_s, input rate_saturated,
                  input capacity_drop, output ready);
endinterface

`default_nettype wire

>>> rtl/sliding_window_rate_meter_top.sv
// Top level of the sliding window byte rate meter: sequencer, registers and output stage.
// Sequence: a sample that computes a rate passes through the 51-bit serial divide; each evicted
//   entry adds a read and check pass, and a full ring adds a read and drop pass. A clear goes
//   straight from acceptance to the result stage.
// Throughput: one transaction in flight; the next is taken once the result is stored.
// Reset: rst_n clears the window (count, pointer, sum, rate) at once; no clearing pass.
`default_nettype none

module sliding_window_rate_meter_top
    import swrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    swrm_in_if.sink          samples,
    swrm_out_if.source       rates
);

    // Sequencer state and window bookkeeping
    state_t           state_reg, state_next;
    logic [PTR_W-1:0] oldest_ptr_reg, oldest_ptr_next;
    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [SUM_W-1:0] window_sum_reg, window_sum_next;
    logic [31:0]      last_rate_reg, last_rate_next;
    logic             sat_reg, sat_next;
    logic             drop_reg, drop_next;

    // Configuration registers
    logic [31:0]      window_ms_reg;
    logic [8:0]       min_count_reg;

    // Per-transaction payload
    logic [31:0]      newest_reg, newest_next;
    logic [31:0]      new_bytes_reg, new_bytes_next;
    logic [SUM_W-1:0] base_reg, base_next;
    logic [NUM_W-1:0] prod_reg, prod_next;
    logic [31:0]      span_reg, span_next;

    // Output stage
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_rate_reg;
    logic             out_sat_reg;
    logic             out_drop_reg;
    logic             out_load;

    // Ring and divider hookup
    logic             wr_en;
    logic             rd_en;
    logic [PTR_W-1:0] slot;
    logic [CNT_W:0]   slot_wide;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic             div_start;
    logic [31:0]      div_quotient;
    div_status_t      div_status;

    logic             in_accept;
    logic             cfg_write;
    logic [PTR_W-1:0] ptr_inc;
    logic [31:0]      age;
    logic             too_old;
    logic             enough;

    // ---------------------------------------------------------------------------------------
    // APB register port: pready is tied high, writes land on the access phase
    // ---------------------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[2] == REG_MIN_COUNT) ? {23'd0, min_count_reg} : window_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg <= WINDOW_MS_RESET;
            min_count_reg <= MIN_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WINDOW_MS: window_ms_reg <= pwdata;
                REG_MIN_COUNT: min_count_reg <= pwdata[8:0];
                default:       window_ms_reg <= window_ms_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------------
    // Ring addressing
    // ---------------------------------------------------------------------------------------
    assign in_accept = samples.valid & samples.ready;
    assign ptr_inc   = (oldest_ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : oldest_ptr_reg + 1'b1;
    // The free slot sits count entries past the oldest one, wrapped at the ring depth
    assign slot_wide = (CNT_W + 1)'(oldest_ptr_reg) + (CNT_W + 1)'(entry_count_reg);
    assign slot      = (slot_wide >= (CNT_W + 1)'(WINDOW_DEPTH))
                     ? PTR_W'(slot_wide - (CNT_W + 1)'(WINDOW_DEPTH))
                     : PTR_W'(slot_wide);

    assign wr_entry.stamp = newest_reg;
    assign wr_entry.bytes = new_bytes_reg;

    // Age of the oldest entry against the newest sample, modulo 2^32
    assign age     = newest_reg - rd_entry.stamp;
    assign too_old = (entry_count_reg > CNT_W'(1)) && (age > window_ms_reg);
    assign enough  = 32'(entry_count_reg) > 32'(min_count_reg);

    swrm_ring u_ring (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (slot),
        .wr_entry (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (oldest_ptr_reg),
        .rd_entry (rd_entry)
    );

    swrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // ---------------------------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (samples.mode == MODE_CLEAR)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (entry_count_reg == CNT_W'(WINDOW_DEPTH))
                    begin
                        state_next = S_FULL_RD;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_FULL_RD:   state_next = S_FULL_DROP;
            S_FULL_DROP: state_next = S_APPEND;
            S_APPEND:    state_next = S_EV_RD;
            S_EV_RD:     state_next = S_EV_CHK;
            S_EV_CHK:
            begin
                if (too_old)
                begin
                    state_next = S_EV_RD;
                end
                else if (enough && (age != 32'd0))
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL1:      state_next = S_MUL2;
            S_MUL2:      state_next = S_DIV_GO;
            S_DIV_GO:    state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // State outputs
    // ---------------------------------------------------------------------------------------
    always_comb
    begin
        samples.ready = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        div_start     = 1'b0;
        unique case (state_reg)
            S_IDLE:    samples.ready = 1'b1;
            S_FULL_RD: rd_en = 1'b1;
            S_APPEND:  wr_en = 1'b1;
            S_EV_RD:   rd_en = 1'b1;
            S_DIV_GO:  div_start = 1'b1;
            default:   rd_en = 1'b0;
        endcase
    end

    // Result may load when the output register is empty or is being drained this cycle
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || rates.ready);

    // ---------------------------------------------------------------------------------------
    // Datapath updates
    // ---------------------------------------------------------------------------------------
    always_comb
    begin
        oldest_ptr_next  = oldest_ptr_reg;
        entry_count_next = entry_count_reg;
        window_sum_next  = window_sum_reg;
        last_rate_next   = last_rate_reg;
        sat_next         = sat_reg;
        drop_next        = drop_reg;
        newest_next      = newest_reg;
        new_bytes_next   = new_bytes_reg;
        base_next        = base_reg;
        prod_next        = prod_reg;
        span_next        = span_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    newest_next    = samples.timestamp_ms;
                    new_bytes_next = samples.sample_bytes;
                    sat_next       = 1'b0;
                    drop_next      = 1'b0;
                    if (samples.mode == MODE_CLEAR)
                    begin
                        // Empty the window and zero the rate
                        oldest_ptr_next  = '0;
                        entry_count_next = '0;
                        window_sum_next  = '0;
                        last_rate_next   = '0;
                    end
                end
            end
            S_FULL_DROP:
            begin
                // Ring full: push the oldest entry out before the new one goes in
                window_sum_next  = window_sum_reg - SUM_W'(rd_entry.bytes);
                oldest_ptr_next  = ptr_inc;
                entry_count_next = entry_count_reg - 1'b1;
                drop_next        = 1'b1;
            end
            S_APPEND:
            begin
                entry_count_next = entry_count_reg + 1'b1;
                window_sum_next  = window_sum_reg + SUM_W'(new_bytes_reg);
            end
            S_EV_CHK:
            begin
                base_next = window_sum_reg - SUM_W'(rd_entry.bytes);
                span_next = age;
                if (too_old)
                begin
                    window_sum_next  = window_sum_reg - SUM_W'(rd_entry.bytes);
                    oldest_ptr_next  = ptr_inc;
                    entry_count_next = entry_count_reg - 1'b1;
                end
                else if (!enough)
                begin
                    last_rate_next = '0;
                end
            end
            S_MUL1:
            begin
                // 31 * base
                prod_next = (NUM_W'(base_reg) << 5) - NUM_W'(base_reg);
            end
            S_MUL2:
            begin
                // 31 * 32 + 8 = 1000
                prod_next = (prod_reg << 5) + (NUM_W'(base_reg) << 3);
            end
            S_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    sat_next       = div_status.saturated;
                    last_rate_next = div_status.saturated ? '1 : div_quotient;
                end
            end
            default:
            begin
                span_next = span_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rates.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            oldest_ptr_reg  <= '0;
            entry_count_reg <= '0;
            window_sum_reg  <= '0;
            last_rate_reg   <= '0;
            sat_reg         <= 1'b0;
            drop_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            oldest_ptr_reg  <= oldest_ptr_next;
            entry_count_reg <= entry_count_next;
            window_sum_reg  <= window_sum_next;
            last_rate_reg   <= last_rate_next;
            sat_reg         <= sat_next;
            drop_reg        <= drop_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg    <= newest_next;
        new_bytes_reg <= new_bytes_next;
        base_reg      <= base_next;
        prod_reg      <= prod_next;
        span_reg      <= span_next;
        if (out_load)
        begin
            out_rate_reg <= last_rate_reg;
            out_sat_reg  <= sat_reg;
            out_drop_reg <= drop_reg;
        end
    end

    // Hold the result until the rate transaction completes
    assign rates.valid            = out_valid_reg;
    assign rates.rate_bytes_per_s = out_rate_reg;
    assign rates.rate_saturated   = out_sat_reg;
    assign rates.capacity_drop    = out_drop_reg;

endmodule

`default_nettype wire

>>> rtl/swrm_ring.sv
// Ring storage of sample timestamps and byte counts, one write and one registered read port.
`default_nettype none

module swrm_ring
    import swrm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [PTR_W-1:0] wr_addr,
    input  wire entry_t           wr_entry,
    input  wire logic             rd_en,
    input  wire logic [PTR_W-1:0] rd_addr,
    output entry_t                rd_entry
);

    entry_t mem_reg [WINDOW_DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

>>> rtl/swrm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module swrm_div
    import swrm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [31:0]      divisor,
    output logic [31:0]           quotient,
    output div_status_t           status
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          dsr_reg, dsr_next;
    logic [33:0]          trial;
    logic                 fits;

    // Trial subtract of the divisor from the remainder with the next dividend bit shifted in
    assign trial = {1'b0, rem_reg, quo_reg[NUM_W-1]} - {2'b00, dsr_reg};
    assign fits  = ~trial[33];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? trial[31:0] : {rem_reg[30:0], quo_reg[NUM_W-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient         = quo_reg[31:0];
    assign status.done      = done_reg;
    assign status.saturated = |quo_reg[NUM_W-1:32];

endmodule

`default_nettype wire

>>> rtl/swrm_checker.sv
// Port-level checker of the rate meter and its bind to the top level.
`default_nettype none

module swrm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] out_rate,
    input wire logic        out_sat,
    input wire logic        out_drop
);

    // A stalled rate transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("rate transaction withdrawn while stalled");

    // A stalled rate transaction keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_rate) && $stable(out_sat) && $stable(out_drop))
        else $error("rate payload changed while stalled");

    // The meter works on one sample at a time: it is busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while the first is in flight");

    // A clamped quotient always reports the full-scale rate
    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_sat |-> out_rate == 32'hFFFF_FFFF)
        else $error("saturated rate is not full scale");

endmodule

bind sliding_window_rate_meter_top swrm_checker u_swrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (rates.valid),
    .out_ready (rates.ready),
    .out_rate  (rates.rate_bytes_per_s),
    .out_sat   (rates.rate_saturated),
    .out_drop  (rates.capacity_drop)
);

`default_nettype wire
